[rtl/core/rvex_pkg.sv]
// Shared constants, opcode and struct types for the reduced RV32 execute unit.
package rvex_pkg;

    localparam int XLEN      = 32;
    localparam int NUM_REGS  = 32;
    localparam int REG_AW    = $clog2(NUM_REGS);
    localparam int RA_REG    = 1;
    localparam int PC_WIDTH  = 16;
    localparam int PORT_PC_W = 16;
    localparam int TGT_W     = 16;
    localparam int MEM_BYTES = 4096;
    localparam int MEM_AW    = $clog2(MEM_BYTES);
    localparam int NUM_BANKS = 4;
    localparam int BANK_AW   = $clog2(NUM_BANKS);
    localparam int ROW_AW    = MEM_AW - BANK_AW;
    localparam int BANK_ROWS = MEM_BYTES / NUM_BANKS;
    localparam int SHAMT_BITS = 5;

    typedef enum logic [4:0] {
        OP_ADD  = 5'd0,
        OP_ADDI = 5'd1,
        OP_AND  = 5'd2,
        OP_LI   = 5'd3,
        OP_MV   = 5'd4,
        OP_OR   = 5'd5,
        OP_SLL  = 5'd6,
        OP_SRL  = 5'd7,
        OP_SUB  = 5'd8,
        OP_XOR  = 5'd9,
        OP_JUMP = 5'd10,
        OP_JAL  = 5'd11,
        OP_BEQ  = 5'd12,
        OP_BNE  = 5'd13,
        OP_BLT  = 5'd14,
        OP_BGE  = 5'd15,
        OP_SB   = 5'd16,
        OP_SH   = 5'd17,
        OP_SW   = 5'd18,
        OP_LW   = 5'd19,
        OP_LH   = 5'd20,
        OP_LB   = 5'd21,
        OP_RET  = 5'd22
    } op_t;

    typedef enum logic [1:0] {
        SIZE_BYTE = 2'd0,
        SIZE_HALF = 2'd1,
        SIZE_WORD = 2'd2
    } mem_size_t;

    typedef struct packed {
        logic              load;
        logic              store;
        mem_size_t         size;
        logic [MEM_AW-1:0] addr;
        logic [XLEN-1:0]   wdata;
    } dmem_req_t;

    typedef struct packed {
        logic [PC_WIDTH-1:0] next_pc;
        logic                wr;
        logic [REG_AW-1:0]   rd;
        logic [XLEN-1:0]     val;
        logic                taken;
        dmem_req_t           mem;
    } exec_res_t;

endpackage

[rtl/core/rvex_regfile.sv]
// 32 x 32 register file: synchronous two-port read, one write, valid bits and write bypass.
module rvex_regfile (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [rvex_pkg::REG_AW-1:0]  ra_addr,
    input  logic [rvex_pkg::REG_AW-1:0]  rb_addr,
    input  logic                         wr_en,
    input  logic [rvex_pkg::REG_AW-1:0]  wr_addr,
    input  logic [rvex_pkg::XLEN-1:0]    wr_data,
    output logic [rvex_pkg::XLEN-1:0]    ra_data,
    output logic [rvex_pkg::XLEN-1:0]    rb_data
);
    import rvex_pkg::*;

    logic [XLEN-1:0]     ram [NUM_REGS];
    logic [NUM_REGS-1:0] valid_reg;
    logic [XLEN-1:0]     qa_reg;
    logic [XLEN-1:0]     qb_reg;
    logic [XLEN-1:0]     byp_reg;
    logic                a_byp_reg;
    logic                b_byp_reg;
    logic                a_vld_reg;
    logic                b_vld_reg;
    logic                wr_live;

    // drop writes to x0
    assign wr_live = wr_en && (wr_addr != '0);

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_live)
        begin
            ram[wr_addr] <= wr_data;
        end
    end

    // read ports, registered; capture write data for same-edge bypass
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            qa_reg  <= ram[ra_addr];
            qb_reg  <= ram[rb_addr];
            byp_reg <= wr_data;
        end
    end

    // valid bits and read selects
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            a_byp_reg <= 1'b0;
            b_byp_reg <= 1'b0;
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_live)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                a_byp_reg <= wr_live && (wr_addr == ra_addr);
                b_byp_reg <= wr_live && (wr_addr == rb_addr);
                a_vld_reg <= valid_reg[ra_addr];
                b_vld_reg <= valid_reg[rb_addr];
            end
        end
    end

    // never-written entries read as zero
    assign ra_data = a_byp_reg ? byp_reg : (a_vld_reg ? qa_reg : '0);
    assign rb_data = b_byp_reg ? byp_reg : (b_vld_reg ? qb_reg : '0);

endmodule

[rtl/core/rvex_dmem.sv]
// Byte data memory in four interleaved banks with wrapping unaligned access and load extension.
module rvex_dmem (
    input  logic                       clk,
    input  rvex_pkg::dmem_req_t        req,
    output logic [rvex_pkg::XLEN-1:0]  load_data
);
    import rvex_pkg::*;

    logic [BANK_AW-1:0] lo;
    logic [ROW_AW-1:0]  row;
    logic [BANK_AW-1:0] lo_reg;
    mem_size_t          size_reg;
    logic [7:0]         bank_q [NUM_BANKS];
    logic [7:0]         b0;
    logic [7:0]         b1;
    logic [7:0]         b2;
    logic [7:0]         b3;

    assign lo  = req.addr[BANK_AW-1:0];
    assign row = req.addr[MEM_AW-1:BANK_AW];

    // one bank per byte lane; a bank below the start lane takes the next row
    for (genvar k = 0; k < NUM_BANKS; k++)
    begin : g_bank
        logic [7:0]         ram [BANK_ROWS];
        logic [7:0]         q_reg;
        logic [BANK_AW-1:0] lane;
        logic [ROW_AW-1:0]  bank_row;
        logic               bank_we;

        assign lane     = BANK_AW'(k) - lo;
        assign bank_row = row + ROW_AW'(BANK_AW'(k) < lo);

        // enable lanes covered by the access size
        always_comb
        begin
            case (req.size)
                SIZE_BYTE: bank_we = req.store && (lane == '0);
                SIZE_HALF: bank_we = req.store && (lane <= BANK_AW'(1));
                SIZE_WORD: bank_we = req.store;
                default:   bank_we = 1'b0;
            endcase
        end

        always_ff @(posedge clk)
        begin
            if (bank_we)
            begin
                ram[bank_row] <= req.wdata[{lane, 3'b000} +: 8];
            end
            if (req.load)
            begin
                q_reg <= ram[bank_row];
            end
        end

        assign bank_q[k] = q_reg;
    end

    // hold lane rotation and size for the data cycle
    always_ff @(posedge clk)
    begin
        if (req.load)
        begin
            lo_reg   <= lo;
            size_reg <= req.size;
        end
    end

    // rotate bytes back into order
    assign b0 = bank_q[lo_reg];
    assign b1 = bank_q[lo_reg + BANK_AW'(1)];
    assign b2 = bank_q[lo_reg + BANK_AW'(2)];
    assign b3 = bank_q[lo_reg + BANK_AW'(3)];

    // sign-extend by size
    always_comb
    begin
        case (size_reg)
            SIZE_BYTE: load_data = {{24{b0[7]}}, b0};
            SIZE_HALF: load_data = {{16{b1[7]}}, b1, b0};
            SIZE_WORD: load_data = {b3, b2, b1, b0};
            default:   load_data = '0;
        endcase
    end

endmodule

[rtl/core/rvex_exec.sv]
// Execute logic: ALU, branch compare, next PC and memory request for one instruction.
module rvex_exec (
    input  rvex_pkg::op_t                   op,
    input  logic [rvex_pkg::REG_AW-1:0]     rd,
    input  logic [rvex_pkg::XLEN-1:0]       a,
    input  logic [rvex_pkg::XLEN-1:0]       b,
    input  logic [rvex_pkg::XLEN-1:0]       imm,
    input  logic [rvex_pkg::PC_WIDTH-1:0]   pc,
    input  logic [rvex_pkg::PC_WIDTH-1:0]   tgt,
    output rvex_pkg::exec_res_t             res
);
    import rvex_pkg::*;

    logic [PC_WIDTH-1:0]   seq_pc;
    logic [XLEN-1:0]       addr_sum;
    logic [SHAMT_BITS-1:0] shamt;
    logic                  eq;
    logic                  lt_s;
    logic                  wr_op;
    logic [XLEN-1:0]       val;

    assign seq_pc   = pc + PC_WIDTH'(1);
    assign addr_sum = a + imm;
    assign shamt    = b[SHAMT_BITS-1:0];
    assign eq       = (a == b);
    assign lt_s     = ($signed(a) < $signed(b));

    always_comb
    begin
        wr_op          = 1'b0;
        val            = '0;
        res.next_pc    = seq_pc;
        res.taken      = 1'b0;
        res.mem.load   = 1'b0;
        res.mem.store  = 1'b0;
        res.mem.size   = SIZE_WORD;
        res.mem.addr   = MEM_AW'(addr_sum);
        res.mem.wdata  = b;

        case (op)
            OP_ADD:  begin val = a + b;        wr_op = 1'b1; end
            OP_ADDI: begin val = a + imm;      wr_op = 1'b1; end
            OP_AND:  begin val = a & b;        wr_op = 1'b1; end
            OP_LI:   begin val = imm;          wr_op = 1'b1; end
            OP_MV:   begin val = a;            wr_op = 1'b1; end
            OP_OR:   begin val = a | b;        wr_op = 1'b1; end
            OP_SLL:  begin val = a << shamt;   wr_op = 1'b1; end
            OP_SRL:  begin val = a >> shamt;   wr_op = 1'b1; end
            OP_SUB:  begin val = a - b;        wr_op = 1'b1; end
            OP_XOR:  begin val = a ^ b;        wr_op = 1'b1; end
            OP_JUMP:
            begin
                res.next_pc = tgt;
                res.taken   = 1'b1;
            end
            OP_JAL:
            begin
                val         = XLEN'(seq_pc);
                wr_op       = 1'b1;
                res.next_pc = tgt;
                res.taken   = 1'b1;
            end
            OP_BEQ:
            begin
                res.taken = eq;
                if (eq) res.next_pc = tgt;
            end
            OP_BNE:
            begin
                res.taken = !eq;
                if (!eq) res.next_pc = tgt;
            end
            OP_BLT:
            begin
                res.taken = lt_s;
                if (lt_s) res.next_pc = tgt;
            end
            OP_BGE:
            begin
                res.taken = !lt_s;
                if (!lt_s) res.next_pc = tgt;
            end
            OP_SB:
            begin
                res.mem.store = 1'b1;
                res.mem.size  = SIZE_BYTE;
            end
            OP_SH:
            begin
                res.mem.store = 1'b1;
                res.mem.size  = SIZE_HALF;
            end
            OP_SW:
            begin
                res.mem.store = 1'b1;
                res.mem.size  = SIZE_WORD;
            end
            OP_LW:
            begin
                res.mem.load = 1'b1;
                res.mem.size = SIZE_WORD;
                wr_op        = 1'b1;
            end
            OP_LH:
            begin
                res.mem.load = 1'b1;
                res.mem.size = SIZE_HALF;
                wr_op        = 1'b1;
            end
            OP_LB:
            begin
                res.mem.load = 1'b1;
                res.mem.size = SIZE_BYTE;
                wr_op        = 1'b1;
            end
            OP_RET:
            begin
                res.next_pc = PC_WIDTH'(a);
                res.taken   = 1'b1;
            end
            default:
            begin
                // unused codes just advance the PC
                wr_op = 1'b0;
            end
        endcase

        // drop writes to x0 and clear the reported write
        res.wr  = wr_op && (rd != '0);
        res.rd  = res.wr ? rd : '0;
        res.val = res.wr ? val : '0;
    end

endmodule

[rtl/core/rv32_subset_execute_unit.sv]
// Top level of the reduced RV32 execute unit: issue, execute and write-back pipeline.
//
// Usage: one decoded instruction word enters on the input channel (in_valid / in_stall)
// with operation, dest_reg, src_a, src_b, immediate and target_index. One result word
// leaves on the output channel (out_valid / out_stall) with next_pc, reg_written,
// written_reg, written_value and branch_taken.
// Words pass the execute, write-back and output registers in order; the input is stalled
// while a word is in execute, so a new word waits until the last reaches write-back.
// The register file is read at acceptance and written at write-back, and the next word's
// operand read waits for that write-back (a same-edge write is bypassed into the read).
// Loads and stores use the banked byte memory: address and store data are applied at
// the end of the execute cycle, load data returns in the write-back cycle.
// Reset: program counter and register file read as zero; data memory is undefined
// until written. No clearing pass; the unit accepts words right after reset.
// Output stall: the finished word holds in the output register; the word behind it
// waits in write-back, and the input is stalled until write-back can drain.
module rv32_subset_execute_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [4:0]                            operation,
    input  logic [rvex_pkg::REG_AW-1:0]           dest_reg,
    input  logic [rvex_pkg::REG_AW-1:0]           src_a,
    input  logic [rvex_pkg::REG_AW-1:0]           src_b,
    input  logic signed [rvex_pkg::XLEN-1:0]      immediate,
    input  logic [rvex_pkg::TGT_W-1:0]            target_index,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [rvex_pkg::PORT_PC_W-1:0]        next_pc,
    output logic                                  reg_written,
    output logic [rvex_pkg::REG_AW-1:0]           written_reg,
    output logic signed [rvex_pkg::XLEN-1:0]      written_value,
    output logic                                  branch_taken
);
    import rvex_pkg::*;

    logic                 accept;
    logic                 w_done;
    logic                 e_valid_reg;
    logic                 e_valid_next;
    logic                 w_valid_reg;
    logic                 w_valid_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [PC_WIDTH-1:0]  pc_reg;

    op_t                  in_op;
    op_t                  e_op_reg;
    logic [REG_AW-1:0]    e_rd_reg;
    logic [XLEN-1:0]      e_imm_reg;
    logic [PC_WIDTH-1:0]  e_tgt_reg;
    logic [REG_AW-1:0]    ra_addr;

    logic [XLEN-1:0]      rs_a;
    logic [XLEN-1:0]      rs_b;
    exec_res_t            ex_res;
    dmem_req_t            dmem_req;
    logic [XLEN-1:0]      load_data;

    logic [PC_WIDTH-1:0]  w_next_pc_reg;
    logic                 w_wr_reg;
    logic [REG_AW-1:0]    w_rd_reg;
    logic [XLEN-1:0]      w_val_reg;
    logic                 w_taken_reg;
    logic                 w_load_reg;
    logic [XLEN-1:0]      w_final;

    logic [PORT_PC_W-1:0] out_next_pc_reg;
    logic                 out_wr_reg;
    logic [REG_AW-1:0]    out_rd_reg;
    logic [XLEN-1:0]      out_val_reg;
    logic                 out_taken_reg;

    // handshake: write-back drains when the output register frees up
    assign w_done   = w_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = e_valid_reg || (w_valid_reg && !w_done);
    assign accept   = in_valid && !in_stall;

    // return reads the link register through port A
    assign in_op   = op_t'(operation);
    assign ra_addr = (in_op == OP_RET) ? REG_AW'(RA_REG) : src_a;

    rvex_regfile u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .ra_addr (ra_addr),
        .rb_addr (src_b),
        .wr_en   (w_done && w_wr_reg),
        .wr_addr (w_rd_reg),
        .wr_data (w_final),
        .ra_data (rs_a),
        .rb_data (rs_b)
    );

    rvex_exec u_exec (
        .op  (e_op_reg),
        .rd  (e_rd_reg),
        .a   (rs_a),
        .b   (rs_b),
        .imm (e_imm_reg),
        .pc  (pc_reg),
        .tgt (e_tgt_reg),
        .res (ex_res)
    );

    // issue memory access only from a live execute cycle
    always_comb
    begin
        dmem_req       = ex_res.mem;
        dmem_req.load  = ex_res.mem.load && e_valid_reg;
        dmem_req.store = ex_res.mem.store && e_valid_reg;
    end

    rvex_dmem u_dmem (
        .clk       (clk),
        .req       (dmem_req),
        .load_data (load_data)
    );

    // merge load data at write-back
    assign w_final = w_load_reg ? load_data : w_val_reg;

    // stage occupancy
    always_comb
    begin
        e_valid_next = accept;
        if (e_valid_reg)
        begin
            w_valid_next = 1'b1;
        end
        else if (w_done)
        begin
            w_valid_next = 1'b0;
        end
        else
        begin
            w_valid_next = w_valid_reg;
        end
        if (w_done)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control state and program counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg   <= 1'b0;
            w_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            pc_reg        <= '0;
        end
        else
        begin
            e_valid_reg   <= e_valid_next;
            w_valid_reg   <= w_valid_next;
            out_valid_reg <= out_valid_next;
            if (e_valid_reg)
            begin
                pc_reg <= ex_res.next_pc;
            end
        end
    end

    // payload: capture at issue, advance to write-back, load output word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            e_op_reg  <= in_op;
            e_rd_reg  <= dest_reg;
            e_imm_reg <= immediate;
            e_tgt_reg <= PC_WIDTH'(target_index);
        end
        if (e_valid_reg)
        begin
            w_next_pc_reg <= ex_res.next_pc;
            w_wr_reg      <= ex_res.wr;
            w_rd_reg      <= ex_res.rd;
            w_val_reg     <= ex_res.val;
            w_taken_reg   <= ex_res.taken;
            w_load_reg    <= ex_res.mem.load && ex_res.wr;
        end
        if (w_done)
        begin
            out_next_pc_reg <= PORT_PC_W'(w_next_pc_reg);
            out_wr_reg      <= w_wr_reg;
            out_rd_reg      <= w_rd_reg;
            out_val_reg     <= w_final;
            out_taken_reg   <= w_taken_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign next_pc       = out_next_pc_reg;
    assign reg_written   = out_wr_reg;
    assign written_reg   = out_rd_reg;
    assign written_value = $signed(out_val_reg);
    assign branch_taken  = out_taken_reg;

`ifndef NO_ASSERTIONS
    // execute always drains into an empty write-back stage
    a_exec_wb_free: assert property (@(posedge clk) disable iff (!rst_n)
        e_valid_reg |-> !w_valid_reg)
        else $error("execute stage holds a word while write-back is occupied");

    // x0 is never reported as written
    a_no_x0_write: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && reg_written) |-> (written_reg != '0))
        else $error("result reports a write to x0");

    // a word without a register write reports zero index and value
    a_clean_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !reg_written) |-> (written_reg == '0 && written_value == '0))
        else $error("result without write carries nonzero register fields");

    // a draining write-back word shows up at the output next cycle
    a_wb_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        w_done |=> out_valid)
        else $error("write-back word did not reach the output register");
`endif

endmodule

[sim/rv32_subset_execute_unit_tb.sv]
// Self-checking testbench for the reduced RV32 execute unit: directed and random words.
`timescale 1ns / 1ps

module rv32_subset_execute_unit_tb;
    import rvex_pkg::*;

    // Opcodes outside the decoded set, which must act as no-ops
    localparam logic [4:0] OP_UNUSED_LO = 5'd23;
    localparam logic [4:0] OP_UNUSED_HI = 5'd31;

    typedef struct packed {
        logic [PORT_PC_W-1:0] next_pc;
        logic                 wr;
        logic [REG_AW-1:0]    rd;
        logic [XLEN-1:0]      val;
        logic                 taken;
    } retire_word_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [4:0]           operation;
    logic [REG_AW-1:0]    dest_reg;
    logic [REG_AW-1:0]    src_a;
    logic [REG_AW-1:0]    src_b;
    logic signed [XLEN-1:0] immediate;
    logic [TGT_W-1:0]     target_index;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [PORT_PC_W-1:0] next_pc;
    logic                 reg_written;
    logic [REG_AW-1:0]    written_reg;
    logic signed [XLEN-1:0] written_value;
    logic                 branch_taken;

    // Architectural state as the testbench sees it
    logic [XLEN-1:0]      arch_regs [NUM_REGS];
    logic [PC_WIDTH-1:0]  arch_pc;
    logic [7:0]           mem_bytes [MEM_BYTES];
    bit                   mem_filled [MEM_BYTES];
    int unsigned          filled_slots [$];

    retire_word_t         pending_retire [$];
    int                   error_count;
    int unsigned          send_idle_pct;
    int unsigned          recv_stall_pct;

    rv32_subset_execute_unit dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Bound the run in case the pipeline hangs
    initial
    begin
        #5000000;
        $display("FAIL rv32_subset_execute_unit");
        $finish;
    end

    function automatic int unsigned byte_slot(logic [XLEN-1:0] addr, int unsigned i);
        return (addr % MEM_BYTES + i) % MEM_BYTES;
    endfunction

    function automatic logic [XLEN-1:0] load_bytes(logic [XLEN-1:0] addr, int unsigned count);
        logic [XLEN-1:0] v;
        int unsigned k;
        v = '0;
        for (k = 0; k < count; k++)
            v[8*k +: 8] = mem_bytes[byte_slot(addr, k)];
        return v;
    endfunction

    function automatic void store_bytes(logic [XLEN-1:0] addr, logic [XLEN-1:0] data,
                                        int unsigned count);
        int unsigned k;
        int unsigned slot;
        for (k = 0; k < count; k++)
        begin
            slot = byte_slot(addr, k);
            mem_bytes[slot] = data[8*k +: 8];
            if (!mem_filled[slot])
            begin
                mem_filled[slot] = 1'b1;
                filled_slots.push_back(slot);
            end
        end
    endfunction

    // Execute one word against the local state and return its retire word
    function automatic retire_word_t execute_model(logic [4:0] op, logic [REG_AW-1:0] rd,
                                                   logic [REG_AW-1:0] ra, logic [REG_AW-1:0] rb,
                                                   logic [XLEN-1:0] imm, logic [TGT_W-1:0] tgt);
        logic [XLEN-1:0]     a;
        logic [XLEN-1:0]     b;
        logic [XLEN-1:0]     addr;
        logic [XLEN-1:0]     val;
        logic [PC_WIDTH-1:0] seq;
        logic [PC_WIDTH-1:0] nxt;
        logic [PC_WIDTH-1:0] jump_to;
        logic                wr;
        logic                taken;
        retire_word_t        r;
        a       = arch_regs[ra];
        b       = arch_regs[rb];
        addr    = a + imm;
        seq     = arch_pc + PC_WIDTH'(1);
        nxt     = seq;
        jump_to = PC_WIDTH'(tgt);
        val     = '0;
        wr      = 1'b0;
        taken   = 1'b0;
        case (op)
            OP_ADD:  begin val = a + b; wr = 1'b1; end
            OP_ADDI: begin val = a + imm; wr = 1'b1; end
            OP_AND:  begin val = a & b; wr = 1'b1; end
            OP_LI:   begin val = imm; wr = 1'b1; end
            OP_MV:   begin val = a; wr = 1'b1; end
            OP_OR:   begin val = a | b; wr = 1'b1; end
            OP_SLL:  begin val = a << b[SHAMT_BITS-1:0]; wr = 1'b1; end
            OP_SRL:  begin val = a >> b[SHAMT_BITS-1:0]; wr = 1'b1; end
            OP_SUB:  begin val = a - b; wr = 1'b1; end
            OP_XOR:  begin val = a ^ b; wr = 1'b1; end
            OP_JUMP: begin nxt = jump_to; taken = 1'b1; end
            OP_JAL:  begin val = XLEN'(seq); wr = 1'b1; nxt = jump_to; taken = 1'b1; end
            OP_BEQ:  taken = (a == b);
            OP_BNE:  taken = (a != b);
            OP_BLT:  taken = ($signed(a) < $signed(b));
            OP_BGE:  taken = !($signed(a) < $signed(b));
            OP_SB:   store_bytes(addr, b, 1);
            OP_SH:   store_bytes(addr, b, 2);
            OP_SW:   store_bytes(addr, b, 4);
            OP_LW:   begin val = load_bytes(addr, 4); wr = 1'b1; end
            OP_LH:
            begin
                val = load_bytes(addr, 2);
                val = {{16{val[15]}}, val[15:0]};
                wr  = 1'b1;
            end
            OP_LB:
            begin
                val = load_bytes(addr, 1);
                val = {{24{val[7]}}, val[7:0]};
                wr  = 1'b1;
            end
            OP_RET:  begin nxt = PC_WIDTH'(arch_regs[RA_REG]); taken = 1'b1; end
            default: ;
        endcase
        if (taken && op >= OP_BEQ && op <= OP_BGE)
            nxt = jump_to;

        // Drop writes to x0
        if (!wr || rd == '0)
        begin
            wr  = 1'b0;
            val = '0;
            rd  = '0;
        end
        else
            arch_regs[rd] = val;
        arch_pc = nxt;

        r.next_pc = PORT_PC_W'(nxt);
        r.wr      = wr;
        r.rd      = rd;
        r.val     = val;
        r.taken   = taken;
        return r;
    endfunction

    // Present one word, hold it until accepted, then maybe idle
    task automatic send_word(logic [4:0] op, logic [REG_AW-1:0] rd, logic [REG_AW-1:0] ra,
                             logic [REG_AW-1:0] rb, logic [XLEN-1:0] imm,
                             logic [TGT_W-1:0] tgt);
        in_valid     <= 1'b1;
        operation    <= op;
        dest_reg     <= rd;
        src_a        <= ra;
        src_b        <= rb;
        immediate    <= imm;
        target_index <= tgt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_retire.push_back(execute_model(op, rd, ra, rb, imm, tgt));
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
    endtask

    // Hold off the sender until every retire word is back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_retire.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic compare_field(string name, logic [XLEN-1:0] want, logic [XLEN-1:0] got);
        if (want !== got)
        begin
            $display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
            error_count++;
        end
    endtask

    // Check each retire word against the oldest prediction; stall the output at random
    always @(posedge clk)
    begin : retire_check
        retire_word_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_retire.size() == 0)
                begin
                    $display("%0t unexpected word: expected none actual next_pc %h val %h",
                             $time, next_pc, written_value);
                    error_count++;
                end
                else
                begin
                    want = pending_retire.pop_front();
                    compare_field("next_pc", XLEN'(want.next_pc), XLEN'(next_pc));
                    compare_field("reg_written", XLEN'(want.wr), XLEN'(reg_written));
                    compare_field("written_reg", XLEN'(want.rd), XLEN'(written_reg));
                    compare_field("written_value", want.val, written_value);
                    compare_field("branch_taken", XLEN'(want.taken), XLEN'(branch_taken));
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    function automatic logic [REG_AW-1:0] pick_reg();
        // Favor a few registers so back-to-back dependencies are common
        if ($urandom_range(99) < 70)
            return REG_AW'($urandom_range(7));
        return REG_AW'($urandom);
    endfunction

    // Steer a load onto bytes that were already written
    task automatic aim_load(inout logic [4:0] op, input logic [REG_AW-1:0] base,
                            inout logic [XLEN-1:0] imm);
        int unsigned width;
        int unsigned slot;
        int unsigned k;
        int          tries;
        bit          ok;
        if (filled_slots.size() == 0)
        begin
            op = OP_SW;
            return;
        end
        width = (op == OP_LW) ? 4 : (op == OP_LH) ? 2 : 1;
        ok    = 1'b0;
        slot  = 0;
        for (tries = 0; tries < 8 && !ok; tries++)
        begin
            slot = filled_slots[$urandom_range(filled_slots.size() - 1)];
            ok   = 1'b1;
            for (k = 0; k < width; k++)
                if (!mem_filled[(slot + k) % MEM_BYTES])
                    ok = 1'b0;
        end
        if (!ok)
            op = OP_LB;
        imm = XLEN'(slot) - arch_regs[base] + (XLEN'($urandom) << MEM_AW);
    endtask

    task automatic send_random_word();
        logic [4:0]        op;
        logic [REG_AW-1:0] rd;
        logic [REG_AW-1:0] ra;
        logic [REG_AW-1:0] rb;
        logic [XLEN-1:0]   imm;
        logic [TGT_W-1:0]  tgt;
        int unsigned       pick;
        rd   = pick_reg();
        ra   = pick_reg();
        rb   = pick_reg();
        imm  = $urandom;
        tgt  = TGT_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 30)
            op = 5'($urandom_range(OP_XOR, OP_ADD));
        else if (pick < 45)
        begin
            op = 5'($urandom_range(OP_BGE, OP_JUMP));
            if ($urandom_range(1))
                rb = ra;
        end
        else if (pick < 50)
            op = OP_RET;
        else if (pick < 70)
            op = 5'($urandom_range(OP_SW, OP_SB));
        else if (pick < 90)
            op = 5'($urandom_range(OP_LB, OP_LW));
        else
        begin
            op  = 5'($urandom_range(OP_UNUSED_HI, 0));
            rd  = REG_AW'($urandom);
            ra  = REG_AW'($urandom);
            rb  = REG_AW'($urandom);
        end
        if (op >= OP_LW && op <= OP_LB)
            aim_load(op, ra, imm);
        send_word(op, rd, ra, rb, imm, tgt);
    endtask

    // Arithmetic, logic, shifts and moves at the value extremes
    task automatic test_alu_ops();
        send_word(OP_LI,   5'd1,  5'd0, 5'd0, 32'h7FFF_FFFF, '0);
        send_word(OP_LI,   5'd2,  5'd0, 5'd0, 32'h8000_0000, '0);
        send_word(OP_LI,   5'd3,  5'd0, 5'd0, 32'hFFFF_FFFF, '0);
        send_word(OP_ADD,  5'd4,  5'd1, 5'd2, '0, '0);
        send_word(OP_ADDI, 5'd5,  5'd1, 5'd0, 32'h0000_0001, '0);
        send_word(OP_AND,  5'd6,  5'd3, 5'd1, '0, '0);
        send_word(OP_OR,   5'd7,  5'd1, 5'd2, '0, '0);
        send_word(OP_XOR,  5'd8,  5'd3, 5'd2, '0, '0);
        send_word(OP_SUB,  5'd9,  5'd2, 5'd1, '0, '0);
        send_word(OP_SLL,  5'd10, 5'd3, 5'd3, '0, '0);
        send_word(OP_SRL,  5'd11, 5'd2, 5'd3, '0, '0);
        send_word(OP_MV,   5'd12, 5'd1, 5'd0, '0, '0);
    endtask

    // Jumps, link, return, PC wrap and each branch, with both taken and not-taken outcomes
    task automatic test_control_flow();
        send_word(OP_JAL,       REG_AW'(RA_REG), 5'd0, 5'd0, '0, 16'hFFFF);
        send_word(OP_UNUSED_LO, 5'd13, 5'd1, 5'd2, 32'hFFFF_FFFF, 16'h0);
        send_word(OP_RET,       5'd0,  5'd0, 5'd0, '0, 16'h0);
        send_word(OP_BEQ,       5'd0,  5'd3, 5'd3, '0, 16'h1234);
        send_word(OP_BNE,       5'd0,  5'd3, 5'd3, '0, 16'h5678);
        send_word(OP_BLT,       5'd0,  5'd2, 5'd12, '0, 16'h00FF);
        send_word(OP_BGE,       5'd0,  5'd2, 5'd12, '0, 16'hFF00);
        send_word(OP_JUMP,      5'd0,  5'd0, 5'd0, '0, 16'hFFFF);
        send_word(OP_JAL,       5'd0,  5'd0, 5'd0, '0, 16'h0000);
    endtask

    // Stores and loads with address wrap and sign extension
    task automatic test_memory_access();
        send_word(OP_SW, 5'd0,  5'd0, 5'd12, 32'hFFFF_FFFE, '0);
        send_word(OP_LW, 5'd13, 5'd0, 5'd0,  32'hFFFF_FFFE, '0);
        send_word(OP_LB, 5'd14, 5'd0, 5'd0,  32'hFFFF_FFFE, '0);
        send_word(OP_SH, 5'd0,  5'd0, 5'd3,  32'd100, '0);
        send_word(OP_LH, 5'd15, 5'd0, 5'd0,  32'd100, '0);
        send_word(OP_SB, 5'd0,  5'd0, 5'd2,  32'd200, '0);
    endtask

    task automatic test_random_phase(int unsigned sender_idle, int unsigned receiver_stall,
                                     int count);
        send_idle_pct  = sender_idle;
        recv_stall_pct = receiver_stall;
        repeat (count) send_random_word();
        drain_results();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        operation      = '0;
        dest_reg       = '0;
        src_a          = '0;
        src_b          = '0;
        immediate      = '0;
        target_index   = '0;
        error_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        arch_pc        = '0;
        foreach (arch_regs[i])
            arch_regs[i] = '0;
        foreach (mem_filled[i])
            mem_filled[i] = 1'b0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_alu_ops();
        test_control_flow();
        test_memory_access();
        drain_results();

        test_random_phase(0, 0, 125);
        test_random_phase(66, 0, 125);
        test_random_phase(0, 66, 125);
        test_random_phase(27, 27, 125);

        // Let any stray word surface before the verdict
        recv_stall_pct = 0;
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("PASS rv32_subset_execute_unit");
        else
            $display("FAIL rv32_subset_execute_unit");
        $finish;
    end

endmodule
